/* design/plsq_pkg.sv */
// Shared types, constants and saturating helpers for the polynomial tracker.
// No dependencies; every other design file imports this package.
`default_nettype none

package plsq_pkg;

  // Width of the sample counter and fraction bits of the estimate format.
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 32;
  localparam int MEAS_SHIFT = FRAC_BITS - 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // Left shift applied to the product before the divisions.
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_32 = 2'd2
  } sh_t;

  // One scaled product request: |x| * m << sh, divided by divs[0..ndiv-1].
  typedef struct packed {
    logic signed [63:0] x;
    logic [63:0]        m;
    sh_t                sh;
    logic [3:0][63:0]   divs;
    logic [2:0]         ndiv;
  } scale_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
    logic [63:0]        raw;
  } scale_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/plsq_div.sv */
// Restoring divider, one quotient bit per cycle, 128-bit by 64-bit,
// quotient magnitude rounded half up. Imports plsq_pkg.
`default_nettype none

module plsq_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] num,
  input  wire logic [63:0]  den,
  output logic              done,
  output logic [127:0]      quo
);
  import plsq_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_RND  = 3'b100
  } dv_state_t;

  dv_state_t    state_r;
  logic [127:0] n_r;
  logic [63:0]  rem_r;
  logic [63:0]  den_r;
  logic [6:0]   cnt_r;
  logic         done_r;

  logic [63:0]  rsh;
  logic         ge;
  logic         rnd_up;

  // One restoring step; the bit shifted out of the remainder forces a subtract.
  always_comb begin
    rsh    = {rem_r[62:0], n_r[127]};
    ge     = rem_r[63] || (rsh >= den_r);
    rnd_up = rem_r >= (den_r - rem_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        DV_IDLE: begin
          if (start) begin
            n_r     <= num;
            den_r   <= den;
            rem_r   <= '0;
            cnt_r   <= 7'd127;
            state_r <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem_r <= ge ? (rsh - den_r) : rsh;
          n_r   <= {n_r[126:0], ge};
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            state_r <= DV_RND;
          end
        end
        DV_RND: begin
          n_r     <= n_r + {127'd0, rnd_up};
          done_r  <= 1'b1;
          state_r <= DV_IDLE;
        end
        default: state_r <= DV_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quo  = n_r;

endmodule

`default_nettype wire

/* design/plsq_scale.sv */
// Scaled product unit: serial shift-add multiply, fixed left shift, then a
// chain of rounded divisions and a signed 64-bit saturation. Uses plsq_div.
`default_nettype none

module plsq_scale (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire plsq_pkg::scale_req_t req,
  output plsq_pkg::scale_rsp_t      rsp
);
  import plsq_pkg::*;

  typedef enum logic [4:0] {
    SC_IDLE  = 5'b00001,
    SC_MUL   = 5'b00010,
    SC_SHIFT = 5'b00100,
    SC_DIV   = 5'b01000,
    SC_DWAIT = 5'b10000
  } sc_state_t;

  sc_state_t        state_r;
  logic             neg_r;
  logic [63:0]      xmag_r;
  logic [63:0]      h_r;
  logic [63:0]      l_r;
  logic [5:0]       cnt_r;
  sh_t              sh_r;
  logic [3:0][63:0] divs_r;
  logic [2:0]       ndiv_r;
  logic [2:0]       idx_r;
  logic [127:0]     w_r;
  logic             done_r;

  logic [64:0]      sum;
  logic             div_start;
  logic             div_done;
  logic [127:0]     div_quo;
  logic             ovf;

  // Shift-add step: add |x| when the low multiplier bit is set.
  always_comb begin
    sum = {1'b0, h_r} + (l_r[0] ? {1'b0, xmag_r} : 65'd0);
  end

  assign div_start = (state_r == SC_DIV) && (idx_r != ndiv_r);

  plsq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (w_r),
    .den   (divs_r[idx_r[1:0]]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        SC_IDLE: begin
          if (start) begin
            neg_r   <= req.x[63];
            xmag_r  <= req.x[63] ? (64'd0 - req.x) : req.x;
            h_r     <= '0;
            l_r     <= req.m;
            cnt_r   <= 6'd63;
            sh_r    <= req.sh;
            divs_r  <= req.divs;
            ndiv_r  <= req.ndiv;
            state_r <= SC_MUL;
          end
        end
        SC_MUL: begin
          h_r   <= sum[64:1];
          l_r   <= {sum[0], l_r[63:1]};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= SC_SHIFT;
          end
        end
        SC_SHIFT: begin
          case (sh_r)
            SH_16:   w_r <= {h_r, l_r} << 16;
            SH_32:   w_r <= {h_r, l_r} << 32;
            default: w_r <= {h_r, l_r};
          endcase
          idx_r   <= '0;
          state_r <= SC_DIV;
        end
        SC_DIV: begin
          if (idx_r == ndiv_r) begin
            done_r  <= 1'b1;
            state_r <= SC_IDLE;
          end else begin
            state_r <= SC_DWAIT;
          end
        end
        SC_DWAIT: begin
          if (div_done) begin
            w_r     <= div_quo;
            idx_r   <= idx_r + 3'd1;
            state_r <= SC_DIV;
          end
        end
        default: state_r <= SC_IDLE;
      endcase
    end
  end

  // Saturate the signed result from the magnitude and the sign of x.
  assign ovf = (w_r[127:64] != 64'd0) || w_r[63];

  always_comb begin
    rsp.done = done_r;
    rsp.raw  = w_r[63:0];
    if (!neg_r) begin
      rsp.value = ovf ? S64_MAX : w_r[63:0];
    end else begin
      rsp.value = ovf ? S64_MIN : (64'd0 - w_r[63:0]);
    end
  end

endmodule

`default_nettype wire

/* design/polynomial_least_squares_tracker_top.sv */
// Top level of the recursive least-squares polynomial tracker: handshakes,
// order register, state and the operation sequencer. Uses plsq_pkg, plsq_scale.
//
//  Channel | Direction | Handshake       | Word
//  in_     | input     | valid / stall   | measurement, sample time, restart
//  out_    | output    | valid / stall   | level, rate, accel, time error
//  cfg_    | input     | valid / ready   | filter order (ready is always high)
//
// One item at a time. Each product runs through the serial multiplier and
// each division through the bit-serial divider; a time error skips them all.
// Reset is synchronous and active low and clears the estimates, count, last
// time and sets the order to 2. A stalled result holds in the output
// register; the next word is taken while it waits.
`default_nettype none

module polynomial_least_squares_tracker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_measurement,
  input  wire logic [31:0] in_sample_time,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_level_estimate,
  output logic [63:0]      out_rate_estimate,
  output logic [63:0]      out_accel_estimate,
  output logic             out_time_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_filter_order
);
  import plsq_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CHECK = 10'b0000000010,
    ST_OP    = 10'b0000000100,
    ST_WAIT  = 10'b0000001000,
    ST_PA    = 10'b0000010000,
    ST_PB    = 10'b0000100000,
    ST_RES   = 10'b0001000000,
    ST_G0    = 10'b0010000000,
    ST_UPD   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } st_t;

  typedef enum logic [2:0] {
    OP_DD  = 3'd0,
    OP_P1  = 3'd1,
    OP_P2  = 3'd2,
    OP_Q   = 3'd3,
    OP_G0A = 3'd4,
    OP_G0B = 3'd5,
    OP_G1  = 3'd6,
    OP_G2  = 3'd7
  } op_t;

  st_t                   state_r;
  op_t                   op_r;
  logic [1:0]            order_cfg_r;
  logic [1:0]            ord_r;

  // Filter state.
  logic signed [63:0]    level_r;
  logic signed [63:0]    rate_r;
  logic signed [63:0]    accel_r;
  logic [31:0]           last_time_r;
  logic [COUNT_BITS-1:0] count_r;

  // Per-item working registers.
  logic signed [63:0]    mq_r;
  logic [31:0]           time_r;
  logic [31:0]           d_r;
  logic [COUNT_BITS-1:0] k_r;
  logic [63:0]           dd_r;
  logic signed [63:0]    p1_r, p2_r, q_r;
  logic signed [63:0]    pa_r, pred0_r, pred1_r, res_r;
  logic signed [63:0]    g0a_r, g0b_r, g1_r, g2_r, g0_r;
  logic                  err_r;

  logic                  out_valid_r;
  logic [63:0]           out_level_r, out_rate_r, out_accel_r;
  logic                  out_err_r;

  logic signed [63:0]    a1, a2;
  logic [63:0]           k64, kp1, kp2, d64, twok1;
  logic                  op_used;
  scale_req_t            req;
  scale_rsp_t            rsp;
  logic                  sc_start;
  logic signed [63:0]    op_val;
  logic                  op_last_pre;
  logic                  op_last;

  assign a1 = (ord_r != 2'd0) ? rate_r : 64'sd0;
  assign a2 = (ord_r == 2'd2) ? accel_r : 64'sd0;

  assign k64   = 64'(k_r);
  assign kp1   = k64 + 64'd1;
  assign kp2   = k64 + 64'd2;
  assign d64   = 64'(d_r);
  assign twok1 = (k64 << 1) - 64'd1;

  // Operand selection for the current scaled product.
  always_comb begin
    req      = '0;
    req.sh   = SH_0;
    req.x    = res_r;
    op_used  = 1'b1;
    case (op_r)
      OP_DD: begin
        req.x = $signed(d64);
        req.m = d64;
        op_used = (ord_r == 2'd2);
      end
      OP_P1: begin
        req.x = a1;
        req.m = d64;
        req.divs[0] = 64'd65536;
        req.ndiv = 3'd1;
        op_used = (ord_r != 2'd0);
      end
      OP_P2: begin
        req.x = a2;
        req.m = dd_r;
        req.divs[0] = 64'd1 << 33;
        req.ndiv = 3'd1;
        op_used = (ord_r == 2'd2);
      end
      OP_Q: begin
        req.x = a2;
        req.m = d64;
        req.divs[0] = 64'd65536;
        req.ndiv = 3'd1;
        op_used = (ord_r == 2'd2);
      end
      OP_G0A: begin
        if (ord_r == 2'd0) begin
          req.m = 64'd1;
          req.divs[0] = k64;
          req.ndiv = 3'd1;
        end else if (ord_r == 2'd1) begin
          req.m = twok1 << 1;
          req.divs[0] = k64;
          req.divs[1] = kp1;
          req.ndiv = 3'd2;
        end else begin
          req.m = ((k64 - 64'd1) << 3) + (k64 - 64'd1);
          req.divs[0] = kp1;
          req.divs[1] = kp2;
          req.ndiv = 3'd2;
        end
      end
      OP_G0B: begin
        req.m = 64'd6;
        req.divs[0] = k64;
        req.divs[1] = kp1;
        req.divs[2] = kp2;
        req.ndiv = 3'd3;
        op_used = (ord_r == 2'd2);
      end
      OP_G1: begin
        req.sh = SH_16;
        req.divs[0] = d64;
        req.divs[1] = k64;
        req.divs[2] = kp1;
        if (ord_r == 2'd1) begin
          req.m = 64'd6;
          req.ndiv = 3'd3;
        end else begin
          req.m = (twok1 << 4) + (twok1 << 1);
          req.divs[3] = kp2;
          req.ndiv = 3'd4;
        end
        op_used = (ord_r != 2'd0);
      end
      default: begin
        req.m = 64'd60;
        req.sh = SH_32;
        req.divs[0] = dd_r;
        req.divs[1] = k64;
        req.divs[2] = kp1;
        req.divs[3] = kp2;
        req.ndiv = 3'd4;
        op_used = (ord_r == 2'd2);
      end
    endcase
  end

  assign sc_start = (state_r == ST_OP) && op_used;

  plsq_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .req   (req),
    .rsp   (rsp)
  );

  // Value written to the current op's destination; skipped ops give zero.
  assign op_val      = (state_r == ST_WAIT) ? rsp.value : 64'sd0;
  assign op_last_pre = (op_r == OP_Q);
  assign op_last     = (op_r == OP_G2);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      order_cfg_r <= 2'd2;
      level_r     <= '0;
      rate_r      <= '0;
      accel_r     <= '0;
      last_time_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Order register write.
      if (cfg_valid && cfg_ready) begin
        order_cfg_r <= cfg_filter_order;
      end
      // Output register drains; in the output state the load below decides.
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mq_r   <= 64'(signed'(in_measurement)) <<< MEAS_SHIFT;
            time_r <= in_sample_time;
            ord_r  <= (order_cfg_r == 2'd3) ? 2'd2 : order_cfg_r;
            if (in_restart) begin
              level_r     <= '0;
              rate_r      <= '0;
              accel_r     <= '0;
              last_time_r <= '0;
              count_r     <= '0;
            end
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          d_r <= time_r - last_time_r;
          k_r <= (count_r < COUNT_MAX) ? (count_r + 1'b1) : COUNT_MAX;
          if (time_r <= last_time_r) begin
            err_r   <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            err_r   <= 1'b0;
            op_r    <= OP_DD;
            state_r <= ST_OP;
          end
        end
        ST_OP, ST_WAIT: begin
          if ((state_r == ST_OP && !op_used) || (state_r == ST_WAIT && rsp.done)) begin
            case (op_r)
              OP_DD:   dd_r  <= (state_r == ST_WAIT) ? rsp.raw : 64'd0;
              OP_P1:   p1_r  <= op_val;
              OP_P2:   p2_r  <= op_val;
              OP_Q:    q_r   <= op_val;
              OP_G0A:  g0a_r <= op_val;
              OP_G0B:  g0b_r <= op_val;
              OP_G1:   g1_r  <= op_val;
              default: g2_r  <= op_val;
            endcase
            if (op_last_pre) begin
              state_r <= ST_PA;
            end else if (op_last) begin
              state_r <= ST_G0;
            end else begin
              op_r    <= op_t'(3'(op_r + 3'd1));
              state_r <= ST_OP;
            end
          end else if (state_r == ST_OP) begin
            state_r <= ST_WAIT;
          end
        end
        ST_PA: begin
          pa_r    <= sat_add(level_r, p1_r);
          pred1_r <= sat_add(a1, q_r);
          state_r <= ST_PB;
        end
        ST_PB: begin
          pred0_r <= sat_add(pa_r, p2_r);
          state_r <= ST_RES;
        end
        ST_RES: begin
          res_r   <= sat_sub(mq_r, pred0_r);
          op_r    <= OP_G0A;
          state_r <= ST_OP;
        end
        ST_G0: begin
          g0_r    <= sat_add(g0a_r, g0b_r);
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          level_r     <= sat_add(pred0_r, g0_r);
          rate_r      <= (ord_r != 2'd0) ? sat_add(pred1_r, g1_r) : 64'sd0;
          accel_r     <= (ord_r == 2'd2) ? sat_add(a2, g2_r) : 64'sd0;
          last_time_r <= time_r;
          count_r     <= k_r;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_level_r <= level_r;
            out_rate_r  <= rate_r;
            out_accel_r <= accel_r;
            out_err_r   <= err_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_level_estimate = out_level_r;
  assign out_rate_estimate  = out_rate_r;
  assign out_accel_estimate = out_accel_r;
  assign out_time_error     = out_err_r;

  // A new result word appears only from the output state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OUT))
    else $error("result word without a finished item");

  // The scale unit only reports completion while the sequencer waits on it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == ST_WAIT)
    else $error("scale unit finished outside a wait");

  // An update only happens for a strictly later sample time.
  a_time_advances: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> time_r > last_time_r)
    else $error("state update without a later sample time");

  // After an update the sample count is never zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |=> count_r != '0)
    else $error("sample count zero after update");

endmodule

`default_nettype wire
